FILE: design/cnag_pkg.sv
// ----------------------------------------------------------------------------
// cnag_pkg
// Shared constants, types and the coordinate fold for the neighbour address
// generator.
// ----------------------------------------------------------------------------
package cnag_pkg;

  // Field widths
  localparam int COORD_BITS   = 10;
  localparam int ROW_W        = 10;
  localparam int GRID_W       = 11;
  localparam int MASK_W       = 25;
  localparam int RADIUS_W     = 2;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 25;

  // Scan geometry
  localparam int MAX_RADIUS     = 3;
  localparam int PATTERN_SIZE   = 5;
  localparam int PATTERN_CENTER = 2;
  localparam int IDX_W          = 3;
  localparam int OFF_W          = 4;
  localparam int MASK_IDX_W     = $clog2(MASK_W);
  localparam int SUM_W          = 13;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_VON_NEUMANN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOORE       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARBITRARY   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd5;

  // Register reset values
  localparam logic [MODE_W-1:0]   RST_MODE   = MODE_MOORE;
  localparam logic [RADIUS_W-1:0] RST_RADIUS = 2'd1;
  localparam logic                RST_WRAP   = 1'b1;
  localparam logic [GRID_W-1:0]   RST_ROWS   = 11'd64;
  localparam logic [GRID_W-1:0]   RST_COLS   = 11'd64;
  localparam logic [MASK_W-1:0]   RST_MASK   = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [RADIUS_W-1:0] radius;
    logic                wrap_torus;
    logic [GRID_W-1:0]   grid_rows;
    logic [GRID_W-1:0]   grid_cols;
    logic [MASK_W-1:0]   offset_mask;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cand_ok;
    logic pend_valid;
    logic last_pos;
    logic slot_free;
  } dp_status_t;

  typedef struct packed {
    logic             in_grid;
    logic [ROW_W-1:0] coord;
  } fold_t;

  // Add an offset to a centre coordinate and fold it once into [0, size)
  function automatic fold_t fold_coord(input logic [ROW_W-1:0] centre,
                                       input logic signed [OFF_W-1:0] off,
                                       input logic [GRID_W-1:0] size);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] n;
    logic signed [SUM_W-1:0] w;
    fold_t res;
    s = $signed(SUM_W'(centre)) + SUM_W'(off);
    n = $signed(SUM_W'(size));
    res.in_grid = !s[SUM_W-1] && (s < n);
    if (s[SUM_W-1]) begin
      w = s + n;
    end else if (s >= n) begin
      w = s - n;
    end else begin
      w = s;
    end
    res.coord = ROW_W'(w[COORD_BITS-1:0]);
    return res;
  endfunction

endpackage

FILE: design/cnag_if.sv
// ----------------------------------------------------------------------------
// cnag_if
// Valid/ready channels of the neighbour address generator: centre input,
// neighbour output and register write.
// ----------------------------------------------------------------------------
interface cnag_in_if;
  logic                      valid;
  logic                      ready;
  logic [cnag_pkg::ROW_W-1:0] center_row;
  logic [cnag_pkg::ROW_W-1:0] center_col;

  modport source (output valid, center_row, center_col, input ready);
  modport sink   (input valid, center_row, center_col, output ready);
endinterface

interface cnag_out_if;
  logic                      valid;
  logic                      ready;
  logic [cnag_pkg::ROW_W-1:0] neighbor_row;
  logic [cnag_pkg::ROW_W-1:0] neighbor_col;
  logic                      is_last;
  logic                      none_found;

  modport source (output valid, neighbor_row, neighbor_col, is_last, none_found,
                  input ready);
  modport sink   (input valid, neighbor_row, neighbor_col, is_last, none_found,
                  output ready);
endinterface

interface cnag_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cnag_pkg::CFG_IDX_W-1:0]  index;
  logic [cnag_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/cnag_cfg_regs.sv
// ----------------------------------------------------------------------------
// cnag_cfg_regs
// Register file for mode, radius, wrapping, grid size and offset mask.
// ----------------------------------------------------------------------------
module cnag_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  logic [cnag_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [cnag_pkg::CFG_DATA_W-1:0] wr_data_i,
  output cnag_pkg::cfg_t cfg_o
);

  cnag_pkg::cfg_t cfg_q, cfg_d;

  // Always take a write beat
  assign wr_ready_o = 1'b1;

  // Decode the write index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (wr_index_i)
        cnag_pkg::CFG_MODE:   cfg_d.mode        = wr_data_i[cnag_pkg::MODE_W-1:0];
        cnag_pkg::CFG_RADIUS: cfg_d.radius      = wr_data_i[cnag_pkg::RADIUS_W-1:0];
        cnag_pkg::CFG_WRAP:   cfg_d.wrap_torus  = wr_data_i[0];
        cnag_pkg::CFG_ROWS:   cfg_d.grid_rows   = wr_data_i[cnag_pkg::GRID_W-1:0];
        cnag_pkg::CFG_COLS:   cfg_d.grid_cols   = wr_data_i[cnag_pkg::GRID_W-1:0];
        cnag_pkg::CFG_MASK:   cfg_d.offset_mask = wr_data_i[cnag_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= cnag_pkg::RST_MODE;
      cfg_q.radius      <= cnag_pkg::RST_RADIUS;
      cfg_q.wrap_torus  <= cnag_pkg::RST_WRAP;
      cfg_q.grid_rows   <= cnag_pkg::RST_ROWS;
      cfg_q.grid_cols   <= cnag_pkg::RST_COLS;
      cfg_q.offset_mask <= cnag_pkg::RST_MASK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/cnag_ctrl.sv
// ----------------------------------------------------------------------------
// cnag_ctrl
// Sequencer: accepts a centre, steps the offset scan, then closes the centre
// with its final beat.
// ----------------------------------------------------------------------------
module cnag_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cnag_pkg::dp_status_t status_i,
  output cnag_pkg::ctrl_cmd_t  cmd_o
);

  cnag_pkg::state_e state_q, state_d;
  logic             stall;

  // Hold the scan when a found neighbour would displace the pending one
  // while the output slot is still occupied
  assign stall = status_i.cand_ok && status_i.pend_valid && !status_i.slot_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cnag_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cnag_pkg::ST_SCAN;
      end
      cnag_pkg::ST_SCAN: begin
        if (!stall && status_i.last_pos) state_d = cnag_pkg::ST_FINISH;
      end
      cnag_pkg::ST_FINISH: begin
        if (status_i.slot_free) state_d = cnag_pkg::ST_IDLE;
      end
      default: state_d = cnag_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      cnag_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cnag_pkg::ST_SCAN: begin
        cmd_o.step = !stall;
      end
      cnag_pkg::ST_FINISH: begin
        cmd_o.finish = status_i.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnag_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/cnag_datapath.sv
// ----------------------------------------------------------------------------
// cnag_datapath
// Offset scan counters, shape test, coordinate fold, one-deep pending
// neighbour and the output register.
// ----------------------------------------------------------------------------
module cnag_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cnag_pkg::cfg_t       cfg_i,
  input  cnag_pkg::ctrl_cmd_t  cmd_i,
  output cnag_pkg::dp_status_t status_o,
  input  logic [cnag_pkg::ROW_W-1:0] center_row_i,
  input  logic [cnag_pkg::ROW_W-1:0] center_col_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [cnag_pkg::ROW_W-1:0] neighbor_row_o,
  output logic [cnag_pkg::ROW_W-1:0] neighbor_col_o,
  output logic                 is_last_o,
  output logic                 none_found_o
);

  localparam int IW  = cnag_pkg::IDX_W;
  localparam int OW  = cnag_pkg::OFF_W;
  localparam int RW  = cnag_pkg::ROW_W;
  localparam int RDW = cnag_pkg::RADIUS_W;
  localparam int MIW = cnag_pkg::MASK_IDX_W;
  localparam logic [RDW-1:0] MaxRad  = RDW'(cnag_pkg::MAX_RADIUS);
  localparam logic [RDW-1:0] PatCtr  = RDW'(cnag_pkg::PATTERN_CENTER);
  localparam logic [IW-1:0]  PatLast = IW'(cnag_pkg::PATTERN_SIZE - 1);

  logic [IW-1:0] outer_q, outer_d, inner_q, inner_d;
  logic [RW-1:0] held_row_q, held_col_q;
  logic [RW-1:0] pend_row_q, pend_col_q;
  logic          pend_valid_q, pend_valid_d;
  logic          out_valid_q, out_valid_d;
  logic [RW-1:0] out_row_q, out_col_q;
  logic          out_last_q, out_none_q;

  logic                 arbitrary;
  logic [RDW-1:0]       rad, base;
  logic [IW-1:0]        span_last;
  logic signed [OW-1:0] off_outer, off_inner, row_off, col_off;
  logic [OW-1:0]        abs_row, abs_col;
  logic [MIW-1:0]       mask_idx;
  logic                 shape_ok, wrap_eff, cand_ok, push_step, slot_free;
  cnag_pkg::fold_t      fold_r, fold_c;

  // Scan geometry for the current mode
  assign arbitrary = cfg_i.mode[1];
  assign rad       = (cfg_i.radius > MaxRad) ? MaxRad : cfg_i.radius;
  assign base      = arbitrary ? PatCtr : rad;
  assign span_last = arbitrary ? PatLast : IW'({rad, 1'b0});

  // Offsets: column outer for the square modes, row outer for the mask
  assign off_outer = $signed(OW'(outer_q)) - $signed(OW'(base));
  assign off_inner = $signed(OW'(inner_q)) - $signed(OW'(base));
  assign row_off   = arbitrary ? off_outer : off_inner;
  assign col_off   = arbitrary ? off_inner : off_outer;
  assign abs_row   = row_off[OW-1] ? OW'(-row_off) : OW'(row_off);
  assign abs_col   = col_off[OW-1] ? OW'(-col_off) : OW'(col_off);
  assign mask_idx  = MIW'(MIW'(outer_q) * MIW'(cnag_pkg::PATTERN_SIZE)) + MIW'(inner_q);

  // Shape test of the current offset
  always_comb begin
    if (arbitrary) begin
      shape_ok = cfg_i.offset_mask[mask_idx];
    end else begin
      shape_ok = !(row_off == '0 && col_off == '0) &&
                 ((cfg_i.mode != cnag_pkg::MODE_VON_NEUMANN) ||
                  (abs_row + abs_col <= OW'(rad)));
    end
  end

  // Fold the candidate onto the grid
  assign fold_r    = cnag_pkg::fold_coord(held_row_q, row_off, cfg_i.grid_rows);
  assign fold_c    = cnag_pkg::fold_coord(held_col_q, col_off, cfg_i.grid_cols);
  assign wrap_eff  = arbitrary || cfg_i.wrap_torus;
  assign cand_ok   = shape_ok && (wrap_eff || (fold_r.in_grid && fold_c.in_grid));

  assign slot_free = !out_valid_q || out_ready_i;
  assign push_step = cmd_i.step && cand_ok && pend_valid_q;

  assign status_o.cand_ok    = cand_ok;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.last_pos   = (outer_q == span_last) && (inner_q == span_last);
  assign status_o.slot_free  = slot_free;

  // Advance the scan counters, inner offset fastest
  always_comb begin
    outer_d = outer_q;
    inner_d = inner_q;
    if (cmd_i.load) begin
      outer_d = '0;
      inner_d = '0;
    end else if (cmd_i.step) begin
      if (inner_q == span_last) begin
        inner_d = '0;
        outer_d = outer_q + IW'(1);
      end else begin
        inner_d = inner_q + IW'(1);
      end
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (cmd_i.load) begin
      pend_valid_d = 1'b0;
    end else if (cmd_i.step && cand_ok) begin
      pend_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (push_step || cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q      <= '0;
      inner_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      outer_q      <= outer_d;
      inner_q      <= inner_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Capture the centre
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      held_row_q <= center_row_i;
      held_col_q <= center_col_i;
    end
  end

  // Hold the latest found neighbour until the next one shows it was not last
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && cand_ok) begin
      pend_row_q <= fold_r.coord;
      pend_col_q <= fold_c.coord;
    end
  end

  // Output register: earlier neighbour, final neighbour or the empty marker
  always_ff @(posedge clk_i) begin
    if (push_step) begin
      out_row_q  <= pend_row_q;
      out_col_q  <= pend_col_q;
      out_last_q <= 1'b0;
      out_none_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_row_q  <= pend_valid_q ? pend_row_q : '0;
      out_col_q  <= pend_valid_q ? pend_col_q : '0;
      out_last_q <= 1'b1;
      out_none_q <= !pend_valid_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign neighbor_row_o = out_row_q;
  assign neighbor_col_o = out_col_q;
  assign is_last_o      = out_last_q;
  assign none_found_o   = out_none_q;

endmodule

FILE: design/ca_neighbour_address_generator.sv
// ----------------------------------------------------------------------------
// ca_neighbour_address_generator
// Emits the grid coordinates of a centre cell's von Neumann, Moore or
// mask-selected neighbours, one beat per neighbour.
//
//   channel     dir  beat contents
//   in_chan_i   in   center_row, center_col
//   out_chan_o  out  neighbor_row, neighbor_col, is_last, none_found
//   cfg_i       in   index (register number), data
//
// A centre is accepted in the idle state; the offset counters then step through
// every scan position ((2*radius+1)^2 for the square modes, 25 for the mask),
// and a final beat closes the centre.
// The scan holds while a found neighbour meets a full, unready output slot.
// Reset restores the register defaults and empties the output; no clearing.
// ----------------------------------------------------------------------------
module ca_neighbour_address_generator (
  input logic        clk_i,
  input logic        rst_ni,
  cnag_in_if.sink    in_chan_i,
  cnag_out_if.source out_chan_o,
  cnag_cfg_if.sink   cfg_i
);

  cnag_pkg::cfg_t       cfg;
  cnag_pkg::ctrl_cmd_t  cmd;
  cnag_pkg::dp_status_t status;

  cnag_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  cnag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_chan_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cnag_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .center_row_i   (in_chan_i.center_row),
    .center_col_i   (in_chan_i.center_col),
    .out_valid_o    (out_chan_o.valid),
    .out_ready_i    (out_chan_o.ready),
    .neighbor_row_o (out_chan_o.neighbor_row),
    .neighbor_col_o (out_chan_o.neighbor_col),
    .is_last_o      (out_chan_o.is_last),
    .none_found_o   (out_chan_o.none_found)
  );

endmodule

FILE: design/cnag_checker.sv
// ----------------------------------------------------------------------------
// cnag_checker
// Port-level checks of the neighbour address generator, bound to the top.
// ----------------------------------------------------------------------------
module cnag_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [cnag_pkg::ROW_W-1:0] neighbor_row_i,
  input logic [cnag_pkg::ROW_W-1:0] neighbor_col_i,
  input logic is_last_i,
  input logic none_found_i
);

  // Stalled output beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat withdrawn under stall");

  // Stalled output beat keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(neighbor_row_i) && $stable(neighbor_col_i) &&
      $stable(is_last_i) && $stable(none_found_i))
    else $error("output beat changed under stall");

  // A new centre is not taken right after one was accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a centre is in progress");

  // The empty marker closes the centre and carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && none_found_i |->
      is_last_i && (neighbor_row_i == '0) && (neighbor_col_i == '0))
    else $error("malformed empty-neighbourhood beat");

endmodule

bind ca_neighbour_address_generator cnag_checker u_cnag_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_chan_i.valid),
  .in_ready_i     (in_chan_i.ready),
  .out_valid_i    (out_chan_o.valid),
  .out_ready_i    (out_chan_o.ready),
  .neighbor_row_i (out_chan_o.neighbor_row),
  .neighbor_col_i (out_chan_o.neighbor_col),
  .is_last_i      (out_chan_o.is_last),
  .none_found_i   (out_chan_o.none_found)
);

FILE: bench/tb_ca_neighbour_address_generator.sv
// ----------------------------------------------------------------------------
// tb_ca_neighbour_address_generator
// Self-checking bench for the neighbour address generator. Directed centres
// cover the grid corners, every mode, radius zero, an empty mask, the mask
// centre bit, mode three and out-of-range centres and grid sizes. Random
// traffic follows under changing register settings and idle patterns. A
// behavioral predictor builds the expected neighbour beats for each accepted
// centre, and a checker compares every output beat against them in order.
// ----------------------------------------------------------------------------
module tb_ca_neighbour_address_generator;

  // Writes to these indexes land on no register
  localparam logic [cnag_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [cnag_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  // Mode three has its mask bit set and scans like mask mode
  localparam logic [cnag_pkg::MODE_W-1:0]    MODE_ALIAS   = 2'd3;
  localparam int MASK_CENTER = cnag_pkg::PATTERN_CENTER * cnag_pkg::PATTERN_SIZE
                               + cnag_pkg::PATTERN_CENTER;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [cnag_pkg::ROW_W-1:0] row;
    logic [cnag_pkg::ROW_W-1:0] col;
    logic                       is_last;
    logic                       none_found;
  } nbr_beat_t;

  logic clk_i;
  logic rst_ni;

  cnag_in_if  in_if ();
  cnag_out_if out_if ();
  cnag_cfg_if cfg_if ();

  ca_neighbour_address_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .cfg_i      (cfg_if)
  );

  // Register shadow
  logic [cnag_pkg::MODE_W-1:0]   cfg_mode;
  logic [cnag_pkg::RADIUS_W-1:0] cfg_radius;
  logic                          cfg_wrap;
  logic [cnag_pkg::GRID_W-1:0]   cfg_rows;
  logic [cnag_pkg::GRID_W-1:0]   cfg_cols;
  logic [cnag_pkg::MASK_W-1:0]   cfg_mask;

  nbr_beat_t expected_nbrs[$];
  int        mismatches;
  int        stall_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Add the offset and fold once into [0, size)
  function automatic logic [cnag_pkg::ROW_W-1:0] fold_axis(input int centre,
                                                           input int off,
                                                           input int size,
                                                           output bit on_grid);
    int s;
    s = centre + off;
    on_grid = (s >= 0) && (s < size);
    if (s < 0) begin
      s = s + size;
    end else if (s >= size) begin
      s = s - size;
    end
    return s[cnag_pkg::ROW_W-1:0];
  endfunction

  function automatic bit locate_neighbour(input logic [cnag_pkg::ROW_W-1:0] r,
                                          input logic [cnag_pkg::ROW_W-1:0] c,
                                          input int dr, input int dc, input bit wrap,
                                          output nbr_beat_t beat);
    bit row_in;
    bit col_in;
    beat.row        = fold_axis(r, dr, cfg_rows, row_in);
    beat.col        = fold_axis(c, dc, cfg_cols, col_in);
    beat.is_last    = 1'b0;
    beat.none_found = 1'b0;
    return wrap || (row_in && col_in);
  endfunction

  // Append one beat to the expected stream
  function automatic void queue_expected(input nbr_beat_t beat);
    expected_nbrs = {expected_nbrs, beat};
  endfunction

  function automatic void predict_neighbours(input logic [cnag_pkg::ROW_W-1:0] r,
                                             input logic [cnag_pkg::ROW_W-1:0] c);
    nbr_beat_t found[$];
    nbr_beat_t beat;
    int        rad;
    int        adr;
    int        adc;
    if (cfg_mode[1]) begin
      // Mask walk: row offset outer, always wraps
      for (int dr = 0; dr < cnag_pkg::PATTERN_SIZE; dr++) begin
        for (int dc = 0; dc < cnag_pkg::PATTERN_SIZE; dc++) begin
          if (cfg_mask[dr * cnag_pkg::PATTERN_SIZE + dc] &&
              locate_neighbour(r, c, dr - cnag_pkg::PATTERN_CENTER,
                               dc - cnag_pkg::PATTERN_CENTER, 1'b1, beat))
            found = {found, beat};
        end
      end
    end else begin
      // Square scan: column offset outer, centre skipped
      rad = cfg_radius;
      for (int dc = -rad; dc <= rad; dc++) begin
        for (int dr = -rad; dr <= rad; dr++) begin
          adr = (dr < 0) ? -dr : dr;
          adc = (dc < 0) ? -dc : dc;
          if (dr == 0 && dc == 0) continue;
          if (cfg_mode == cnag_pkg::MODE_VON_NEUMANN && adr + adc > rad) continue;
          if (locate_neighbour(r, c, dr, dc, cfg_wrap, beat)) found = {found, beat};
        end
      end
    end
    if (found.size() == 0) begin
      beat.row        = '0;
      beat.col        = '0;
      beat.is_last    = 1'b1;
      beat.none_found = 1'b1;
      found = {found, beat};
    end else begin
      found[found.size() - 1].is_last = 1'b1;
    end
    foreach (found[i]) queue_expected(found[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Hold valid until the register beat is taken; the caller drops valid
  task automatic write_reg(input logic [cnag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cnag_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      cnag_pkg::CFG_MODE:   cfg_mode   = value[cnag_pkg::MODE_W-1:0];
      cnag_pkg::CFG_RADIUS: cfg_radius = value[cnag_pkg::RADIUS_W-1:0];
      cnag_pkg::CFG_WRAP:   cfg_wrap   = value[0];
      cnag_pkg::CFG_ROWS:   cfg_rows   = value[cnag_pkg::GRID_W-1:0];
      cnag_pkg::CFG_COLS:   cfg_cols   = value[cnag_pkg::GRID_W-1:0];
      cnag_pkg::CFG_MASK:   cfg_mask   = value[cnag_pkg::MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Write all six registers; unused upper data bits carry noise
  task automatic set_config(input logic [cnag_pkg::MODE_W-1:0] mode,
                            input logic [cnag_pkg::RADIUS_W-1:0] rad,
                            input logic wrap,
                            input logic [cnag_pkg::GRID_W-1:0] rows,
                            input logic [cnag_pkg::GRID_W-1:0] cols,
                            input logic [cnag_pkg::MASK_W-1:0] mask);
    write_reg(cnag_pkg::CFG_MODE,   cnag_pkg::CFG_DATA_W'({$urandom, mode}));
    write_reg(cnag_pkg::CFG_RADIUS, cnag_pkg::CFG_DATA_W'({$urandom, rad}));
    write_reg(cnag_pkg::CFG_WRAP,   cnag_pkg::CFG_DATA_W'({$urandom, wrap}));
    write_reg(cnag_pkg::CFG_ROWS,   cnag_pkg::CFG_DATA_W'({$urandom, rows}));
    write_reg(cnag_pkg::CFG_COLS,   cnag_pkg::CFG_DATA_W'({$urandom, cols}));
    write_reg(cnag_pkg::CFG_MASK,   cnag_pkg::CFG_DATA_W'(mask));
    cfg_if.valid <= 1'b0;
  endtask

  // Send one centre, with an optional random gap ahead of it
  task automatic send_centre(input logic [cnag_pkg::ROW_W-1:0] r,
                             input logic [cnag_pkg::ROW_W-1:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid      <= 1'b1;
    in_if.center_row <= r;
    in_if.center_col <= c;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_neighbours(r, c);
  endtask

  // Stop sending and wait until every expected beat has arrived
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_nbrs.size() != 0);
  endtask

  // Receiver stalls
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Checker and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    nbr_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_nbrs.size() == 0) begin
        $error("unexpected neighbour beat: row %0d col %0d last %0b none %0b",
               out_if.neighbor_row, out_if.neighbor_col, out_if.is_last,
               out_if.none_found);
        mismatches++;
      end else begin
        want = expected_nbrs.pop_front();
        if (out_if.neighbor_row !== want.row) begin
          $error("neighbor_row: expected %0d, got %0d", want.row, out_if.neighbor_row);
          mismatches++;
        end
        if (out_if.neighbor_col !== want.col) begin
          $error("neighbor_col: expected %0d, got %0d", want.col, out_if.neighbor_col);
          mismatches++;
        end
        if (out_if.is_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, out_if.is_last);
          mismatches++;
        end
        if (out_if.none_found !== want.none_found) begin
          $error("none_found: expected %0b, got %0b", want.none_found, out_if.none_found);
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which no beat moves on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: Moore, radius one, wrapping 64x64 grid
  task automatic test_reset_defaults();
    send_centre(10'd0, 10'd0);
    send_centre(10'd63, 10'd63);
    drain();
  endtask

  task automatic test_von_neumann();
    set_config(cnag_pkg::MODE_VON_NEUMANN, 2'd3, 1'b0, 11'd16, 11'd16, '0);
    send_centre(10'd0, 10'd0);
    send_centre(10'd15, 10'd15);
    send_centre(10'd8, 10'd8);
    drain();
    set_config(cnag_pkg::MODE_VON_NEUMANN, 2'd1, 1'b1, 11'd16, 11'd16, '0);
    send_centre(10'd0, 10'd15);
    send_centre(10'd1, 10'd1);
    drain();
  endtask

  task automatic test_moore();
    set_config(cnag_pkg::MODE_MOORE, 2'd3, 1'b0, 11'd4, 11'd4, '0);
    send_centre(10'd0, 10'd0);
    send_centre(10'd2, 10'd1);
    drain();
    set_config(cnag_pkg::MODE_MOORE, 2'd3, 1'b1, 11'd4, 11'd4, '0);
    send_centre(10'd3, 10'd3);
    drain();
    set_config(cnag_pkg::MODE_MOORE, 2'd2, 1'b1, 11'd1024, 11'd1024, '0);
    send_centre(10'd1023, 10'd0);
    drain();
  endtask

  task automatic test_arbitrary();
    // Full mask, centre included; wrap register has no say here
    set_config(cnag_pkg::MODE_ARBITRARY, 2'd1, 1'b0, 11'd4, 11'd4, '1);
    send_centre(10'd0, 10'd0);
    drain();
    // Empty mask gives the no-neighbour beat
    set_config(cnag_pkg::MODE_ARBITRARY, 2'd1, 1'b0, 11'd16, 11'd16, '0);
    send_centre(10'd5, 10'd5);
    drain();
    set_config(cnag_pkg::MODE_ARBITRARY, 2'd3, 1'b1, 11'd16, 11'd16,
               cnag_pkg::MASK_W'(1) << MASK_CENTER);
    send_centre(10'd3, 10'd2);
    drain();
    set_config(MODE_ALIAS, 2'd0, 1'b0, 11'd8, 11'd8, cnag_pkg::MASK_W'($urandom));
    send_centre(10'd1, 10'd2);
    drain();
    set_config(cnag_pkg::MODE_ARBITRARY, 2'd2, 1'b1, 11'd1024, 11'd1024, '1);
    send_centre(10'd1023, 10'd1023);
    drain();
  endtask

  task automatic test_corner_cases();
    // Radius zero scans only the centre, which is skipped
    set_config(cnag_pkg::MODE_MOORE, 2'd0, 1'b1, 11'd16, 11'd16, '0);
    send_centre(10'd2, 10'd2);
    drain();
    // Single-cell grid without wrap: every neighbour drops off
    set_config(cnag_pkg::MODE_MOORE, 2'd1, 1'b0, 11'd1, 11'd1, '0);
    send_centre(10'd0, 10'd0);
    drain();
    // Grid sizes outside the normal range, folded once
    set_config(cnag_pkg::MODE_VON_NEUMANN, 2'd2, 1'b1, 11'd0, 11'd2047, '0);
    send_centre(10'd1023, 10'd1023);
    drain();
    set_config(cnag_pkg::MODE_MOORE, 2'd1, 1'b0, 11'd2047, 11'd0, '0);
    send_centre(10'd0, 10'd5);
    drain();
    // Centre beyond the grid
    set_config(cnag_pkg::MODE_MOORE, 2'd1, 1'b1, 11'd16, 11'd16, '0);
    write_reg(CFG_SPARE_LO, cnag_pkg::CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, '1);
    cfg_if.valid <= 1'b0;
    send_centre(10'd600, 10'd1000);
    drain();
  endtask

  function automatic logic [cnag_pkg::GRID_W-1:0] pick_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return cnag_pkg::GRID_W'($urandom_range(4, 16));
      6, 7:             return cnag_pkg::GRID_W'($urandom_range(4, 1024));
      8:                return $urandom_range(1) ? cnag_pkg::GRID_W'(1024)
                                                 : cnag_pkg::GRID_W'(4);
      default:          return cnag_pkg::GRID_W'($urandom_range(2047));
    endcase
  endfunction

  // Near the grid edges four times in ten, where folding matters
  function automatic logic [cnag_pkg::ROW_W-1:0] pick_coord(
      input logic [cnag_pkg::GRID_W-1:0] size);
    int lim;
    lim = (size > 1024) ? 1024 : ((size == 0) ? 1 : size);
    case ($urandom_range(9))
      0, 1:    return cnag_pkg::ROW_W'($urandom_range(2));
      2, 3:    return cnag_pkg::ROW_W'(lim - 1 - $urandom_range(2));
      4:       return cnag_pkg::ROW_W'($urandom);
      default: return cnag_pkg::ROW_W'($urandom_range(lim - 1));
    endcase
  endfunction

  task automatic randomize_config();
    logic [cnag_pkg::MODE_W-1:0]   mode;
    logic [cnag_pkg::RADIUS_W-1:0] rad;
    logic [cnag_pkg::MASK_W-1:0]   mask;
    case ($urandom_range(9))
      0, 1, 2: mode = cnag_pkg::MODE_VON_NEUMANN;
      3, 4, 5: mode = cnag_pkg::MODE_MOORE;
      6, 7, 8: mode = cnag_pkg::MODE_ARBITRARY;
      default: mode = MODE_ALIAS;
    endcase
    rad  = ($urandom_range(9) == 0) ? cnag_pkg::RADIUS_W'(0)
                                    : cnag_pkg::RADIUS_W'($urandom_range(1, 3));
    mask = cnag_pkg::MASK_W'($urandom);
    if ($urandom_range(1)) mask = mask & cnag_pkg::MASK_W'($urandom);
    set_config(mode, rad, 1'($urandom_range(1)), pick_size(), pick_size(), mask);
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle, input int items);
    int sent;
    int burst;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    while (sent < items) begin
      randomize_config();
      burst = $urandom_range(12, 28);
      if (burst > items - sent) burst = items - sent;
      repeat (burst) begin
        send_centre(pick_coord(cfg_rows), pick_coord(cfg_cols));
        sent++;
      end
      drain();
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.center_row <= '0;
    in_if.center_col <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    cfg_mode         = cnag_pkg::RST_MODE;
    cfg_radius       = cnag_pkg::RST_RADIUS;
    cfg_wrap         = cnag_pkg::RST_WRAP;
    cfg_rows         = cnag_pkg::RST_ROWS;
    cfg_cols         = cnag_pkg::RST_COLS;
    cfg_mask         = cnag_pkg::RST_MASK;
    send_idle_pct    = 13;
    recv_idle_pct    = 49;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_von_neumann();
    test_moore();
    test_arbitrary();
    test_corner_cases();
    test_random_traffic(13, 49, 133);
    test_random_traffic(49, 13, 133);
    test_random_traffic(0, 0, 133);

    // Let any stray beat show up before closing
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
